// File: rtl/core/idea_pkg.sv
// Package for the IDEA cipher unit: sizes, register indexes, state codes.
// It also holds the forward key schedule, a rotate helper and a times-six index helper.
// It depends on nothing else.
package idea_pkg;

  localparam int ROUND_COUNT  = 8;
  localparam int SUBKEY_COUNT = 52;
  localparam int KEY_ROT      = 25;
  localparam int SK_DEPTH     = 64;
  localparam int SK_AW        = $clog2(SK_DEPTH);

  localparam logic [3:0] ROUNDS = 4'(ROUND_COUNT);

  localparam logic [1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [1:0] REG_KEY_LOWER = 2'd1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_LOAD = 14'b00000000000010,
    S_M1   = 14'b00000000000100,
    S_M2   = 14'b00000000001000,
    S_M3   = 14'b00000000010000,
    S_M4   = 14'b00000000100000,
    S_UPD  = 14'b00000001000000,
    S_F1   = 14'b00000010000000,
    S_F2   = 14'b00000100000000,
    S_F3   = 14'b00001000000000,
    S_BSEL = 14'b00010000000000,
    S_BSQ  = 14'b00100000000000,
    S_BMU  = 14'b01000000000000,
    S_BCAP = 14'b10000000000000
  } state_t;

  function automatic logic [127:0] rotl(logic [127:0] v, int n);
    return (v << n) | (v >> (128 - n));
  endfunction

  // Subkey k: word k%8 of the key rotated left by 25*(k/8).
  function automatic logic [15:0] fwd_subkey(logic [127:0] key, logic [SK_AW-1:0] k);
    logic [127:0] rk;
    logic [2:0]   c;
    c = k[2:0];
    case (k[5:3])
      3'd1:    rk = rotl(key, (1 * KEY_ROT) % 128);
      3'd2:    rk = rotl(key, (2 * KEY_ROT) % 128);
      3'd3:    rk = rotl(key, (3 * KEY_ROT) % 128);
      3'd4:    rk = rotl(key, (4 * KEY_ROT) % 128);
      3'd5:    rk = rotl(key, (5 * KEY_ROT) % 128);
      3'd6:    rk = rotl(key, (6 * KEY_ROT) % 128);
      default: rk = key;
    endcase
    return rk[{~c, 4'b0000} +: 16];
  endfunction

  function automatic logic [SK_AW-1:0] mul6(logic [3:0] x);
    return SK_AW'({2'b00, x} << 2) + SK_AW'({2'b00, x} << 1);
  endfunction

endpackage

// File: rtl/core/idea_block_cipher_unit.sv
// IDEA cipher unit: key registers, subkey sequencer, shared modular multiplier.
// Depends on idea_pkg and idea_ram.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_stall   | mode, in_word0..in_word3
//  out     | out_valid / out_stall | out_word0..out_word3
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each of the 8 rounds fetches six subkeys (through the one RAM read port when
// decrypting, from the forward schedule when encrypting), then makes four passes
// through the one 16x16 modulo-65537 multiplier; the output transform follows.
// After reset or a key write the schedule build runs (18 inverses by repeated
// square-and-multiply, 34 plain writes); blocks are held off then.
// Reset is synchronous; a waiting result holds while out_stall is high.
module idea_block_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] in_word0,
  input  logic [15:0] in_word1,
  input  logic [15:0] in_word2,
  input  logic [15:0] in_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_word0,
  output logic [15:0] out_word1,
  output logic [15:0] out_word2,
  output logic [15:0] out_word3,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import idea_pkg::*;

  state_t state;
  logic [63:0] key_upper, key_lower;
  logic [127:0] key;
  logic mode_q;
  logic [15:0] x0, x1, x2, x3, a, d, p;
  logic [15:0] z [6];
  logic [3:0] rnd;
  logic [2:0] lcnt;
  logic [15:0] fwd_q;
  // multiplier
  logic [15:0] op_a, op_b, opa_q, opb_q, mres;
  logic [31:0] prod;
  logic mul_en;
  // schedule build
  logic [3:0] bi;
  logic [2:0] bpos;
  logic [3:0] icnt;
  logic [15:0] inv_r, inv_base;
  logic [SK_AW-1:0] kidx, widx, raddr, sbase;
  logic [15:0] fk, rdata, wdata;
  logic we, edge_rnd, b_last;
  logic [15:0] bsum, csum, q, s;
  logic in_acc, cfg_acc;

  assign key       = {key_upper, key_lower};
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE) || cfg_valid;

  // modular product of the last issued pair, zero standing for 65536
  always_comb begin
    if (opa_q == 16'd0) begin
      mres = 16'd1 - opb_q;
    end else if (opb_q == 16'd0) begin
      mres = 16'd1 - opa_q;
    end else if (prod[15:0] < prod[31:16]) begin
      mres = prod[15:0] - prod[31:16] + 16'd1;
    end else begin
      mres = prod[15:0] - prod[31:16];
    end
  end

  assign bsum = x1 + z[1];
  assign csum = x2 + z[2];
  assign q    = mres;
  assign s    = p + mres;

  always_comb begin
    mul_en = 1'b1;
    op_a   = 16'd0;
    op_b   = 16'd0;
    case (state)
      S_M1, S_F1: begin
        op_a = x0;
        op_b = z[0];
      end
      S_M2, S_F2: begin
        op_a = x3;
        op_b = z[3];
      end
      S_M3: begin
        op_a = a ^ csum;
        op_b = z[4];
      end
      S_M4: begin
        op_a = (bsum ^ d) + mres;
        op_b = z[5];
      end
      S_BSQ: begin
        op_a = inv_r;
        op_b = inv_r;
      end
      S_BMU: begin
        op_a = mres;
        op_b = inv_base;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod  <= op_a * op_b;
      opa_q <= op_a;
      opb_q <= op_b;
    end
  end

  // decryption subkey source for entry (bi, bpos)
  assign edge_rnd = (bi == 4'd0) || (bi == ROUNDS);
  always_comb begin
    case (bpos)
      3'd0:    kidx = mul6(ROUNDS - bi);
      3'd1:    kidx = mul6(ROUNDS - bi) + (edge_rnd ? SK_AW'(1) : SK_AW'(2));
      3'd2:    kidx = mul6(ROUNDS - bi) + (edge_rnd ? SK_AW'(2) : SK_AW'(1));
      3'd3:    kidx = mul6(ROUNDS - bi) + SK_AW'(3);
      default: kidx = mul6(ROUNDS - bi - 4'd1) + SK_AW'(bpos);
    endcase
  end
  assign fk     = fwd_subkey(key, kidx);
  assign widx   = mul6(bi) + SK_AW'(bpos);
  assign b_last = (bi == ROUNDS) && (bpos == 3'd3);

  always_comb begin
    we    = 1'b0;
    wdata = fk;
    if (state == S_BSEL && bpos != 3'd0 && bpos != 3'd3) begin
      we    = 1'b1;
      wdata = (bpos == 3'd1 || bpos == 3'd2) ? 16'd0 - fk : fk;
    end else if (state == S_BCAP && icnt == 4'd14) begin
      we    = 1'b1;
      wdata = mres;
    end
  end

  assign sbase = mul6(rnd);
  assign raddr = sbase + SK_AW'(lcnt);

  idea_ram #(.WIDTH(16), .DEPTH(SK_DEPTH)) u_inv_ram (
    .clk  (clk),
    .we   (we),
    .waddr(widx),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    fwd_q <= fwd_subkey(key, raddr);
    if (rst) begin
      state     <= S_BSEL;
      key_upper <= 64'd0;
      key_lower <= 64'd0;
      bi        <= 4'd0;
      bpos      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_F3) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER) begin
              if (cfg_index == REG_KEY_UPPER) begin
                key_upper <= cfg_data;
              end else begin
                key_lower <= cfg_data;
              end
              bi    <= 4'd0;
              bpos  <= 3'd0;
              state <= S_BSEL;
            end
          end else if (in_acc) begin
            mode_q <= mode;
            x0     <= in_word0;
            x1     <= in_word1;
            x2     <= in_word2;
            x3     <= in_word3;
            rnd    <= 4'd0;
            lcnt   <= 3'd0;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (lcnt != 3'd0) begin
            z[3'(lcnt - 3'd1)] <= mode_q ? rdata : fwd_q;
          end
          if (lcnt == 3'd6) begin
            lcnt  <= 3'd0;
            state <= (rnd == ROUNDS) ? S_F1 : S_M1;
          end else begin
            lcnt <= lcnt + 3'd1;
          end
        end
        S_M1: state <= S_M2;
        S_M2: begin
          a     <= mres;
          state <= S_M3;
        end
        S_M3: begin
          d     <= mres;
          state <= S_M4;
        end
        S_M4: begin
          p     <= mres;
          state <= S_UPD;
        end
        S_UPD: begin
          x0    <= a ^ q;
          x1    <= csum ^ q;
          x2    <= bsum ^ s;
          x3    <= d ^ s;
          rnd   <= rnd + 4'd1;
          state <= S_LOAD;
        end
        S_F1: state <= S_F2;
        S_F2: begin
          // hold word 0 aside so a waiting result keeps its payload
          a     <= mres;
          state <= S_F3;
        end
        S_F3: begin
          // wait for the output slot to drain
          if (!out_valid || !out_stall) begin
            out_word0 <= a;
            out_word1 <= x2 + z[1];
            out_word2 <= x1 + z[2];
            out_word3 <= mres;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_BSEL: begin
          if (bpos == 3'd0 || bpos == 3'd3) begin
            inv_r    <= fk;
            inv_base <= fk;
            icnt     <= 4'd0;
            state    <= S_BSQ;
          end else if (bpos == 3'd5) begin
            bpos <= 3'd0;
            bi   <= bi + 4'd1;
          end else begin
            bpos <= bpos + 3'd1;
          end
        end
        S_BSQ: state <= S_BMU;
        S_BMU: state <= S_BCAP;
        S_BCAP: begin
          if (icnt == 4'd14) begin
            if (b_last) begin
              state <= S_IDLE;
            end else begin
              bpos  <= bpos + 3'd1;
              state <= S_BSEL;
            end
          end else begin
            inv_r <= mres;
            icnt  <= icnt + 4'd1;
            state <= S_BSQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_LOAD)
    else $error("accepted block did not start subkey fetch");
  a_key_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER)
    |=> state == S_BSEL)
    else $error("key write did not restart schedule build");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> rnd < ROUNDS)
    else $error("round counter past last round");
  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    state == S_F3 && !out_valid |=> out_valid)
    else $error("finished block not posted");
`endif

endmodule

// File: rtl/core/idea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; holds the decryption subkeys of the cipher unit.
module idea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
